@@ design/postfix_stack_evaluator_assert.svh @@
// Assertion macros shared by the evaluator RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_ASSERT_SVH

// Same-cycle implication.
`define PSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pse_pkg.sv @@
package pse_pkg;

    localparam int DATA_W      = 32;
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 2;

    localparam logic [FUNC_W-1:0] FN_PUSH = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SUB  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_MUL  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DIV  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 2'd3;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_PUSH,
        ACT_POP
    } act_t;

    // Controller to datapath
    typedef struct packed {
        logic                accept;
        logic                alu_load;
        logic                div_start;
        logic                div_step;
        logic                div_fix;
        logic                commit;
        act_t                action;
        logic [STATUS_W-1:0] status;
    } ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic few_entries;
        logic rhs_zero;
        logic div_last;
        logic out_free;
    } stat_t;

endpackage

@@ design/pse_if.sv @@
interface pse_tok_if;
    import pse_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] operand_value;

    modport source (output valid, output func, output operand_value, input ready);
    modport sink (input valid, input func, input operand_value, output ready);
endinterface

interface pse_res_if;
    import pse_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       stack_depth;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output top_value, output stack_depth, output status,
                    input ready);
    modport sink (input valid, input top_value, input stack_depth, input status,
                  output ready);
endinterface

@@ design/pse_ctrl.sv @@
module pse_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      tok_valid,
    input  logic [pse_pkg::FUNC_W-1:0] tok_func,
    output logic                      tok_ready,
    input  pse_pkg::stat_t            stat,
    output pse_pkg::ctrl_t            cmd
);
    import pse_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_FIX,
        S_FIN
    } state_t;

    state_t              state_reg, state_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    act_t                act_reg, act_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                accept;

    assign tok_ready = (state_reg == S_IDLE);
    assign accept    = tok_valid && tok_ready;

    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        act_next    = act_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next   = tok_func;
                    act_next    = ACT_NONE;
                    status_next = ST_OK;
                    state_next  = S_FIN;
                    priority if (tok_func == FN_PUSH)
                    begin
                        if (stat.full)
                            status_next = ST_OVERFLOW;
                        else
                            act_next = ACT_PUSH;
                    end
                    else if (tok_func == FN_ADD || tok_func == FN_SUB ||
                             tok_func == FN_MUL || tok_func == FN_DIV)
                    begin
                        if (stat.few_entries)
                            status_next = ST_UNDERFLOW;
                        else if (tok_func == FN_DIV && stat.rhs_zero)
                            status_next = ST_DIVZERO;
                        else
                        begin
                            act_next   = ACT_POP;
                            state_next = S_EXEC;
                        end
                    end
                    else
                    begin
                        // unused code: drop the token
                    end
                end
            end
            S_EXEC:
            begin
                if (func_reg == FN_DIV)
                    state_next = S_DIV;
                else
                    state_next = S_FIN;
            end
            S_DIV:
            begin
                if (stat.div_last)
                    state_next = S_FIX;
            end
            S_FIX:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.accept    = accept;
        cmd.alu_load  = (state_reg == S_EXEC) && (func_reg != FN_DIV);
        cmd.div_start = (state_reg == S_EXEC) && (func_reg == FN_DIV);
        cmd.div_step  = (state_reg == S_DIV);
        cmd.div_fix   = (state_reg == S_FIX);
        cmd.commit    = (state_reg == S_FIN) && stat.out_free;
        cmd.action    = act_reg;
        cmd.status    = status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            func_reg   <= FN_PUSH;
            act_reg    <= ACT_NONE;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            func_reg   <= func_next;
            act_reg    <= act_next;
            status_reg <= status_next;
        end
    end

endmodule

@@ design/pse_datapath.sv @@
module pse_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [pse_pkg::DATA_W-1:0] operand_value,
    input  logic [pse_pkg::FUNC_W-1:0] func,
    input  pse_pkg::ctrl_t             cmd,
    output pse_pkg::stat_t             stat,
    pse_res_if.source                  res
);
    import pse_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    // entries below the top; the top itself lives in top_reg
    logic [DATA_W-1:0]   mem [STACK_DEPTH];
    logic [DATA_W-1:0]   rd_data_reg;
    logic [DATA_W-1:0]   top_reg, top_next;
    logic [DATA_W-1:0]   val_reg;
    logic [DATA_W-1:0]   res_reg;
    logic [DEPTH_W-1:0]  sp_reg, sp_next;

    logic [DATA_W-1:0]   rem_reg;
    logic [DATA_W-1:0]   quo_reg;
    logic [DATA_W-1:0]   dsor_reg;
    logic                neg_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_top_reg;
    logic [DEPTH_W-1:0]  out_depth_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic                mem_we;
    logic [DEPTH_W-1:0]  sp_minus2;
    logic [DEPTH_W-1:0]  sp_minus1;
    logic [DATA_W:0]     rem_shift;
    logic [DATA_W:0]     rem_diff;

    assign sp_minus2 = sp_reg - DEPTH_W'(2);
    assign sp_minus1 = sp_reg - DEPTH_W'(1);
    assign rd_addr   = sp_minus2[ADDR_W-1:0];
    assign wr_addr   = sp_minus1[ADDR_W-1:0];
    assign mem_we    = cmd.commit && (cmd.action == ACT_PUSH) && (sp_reg != '0);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= top_reg;
        if (cmd.accept)
            rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        unique case (cmd.action)
            ACT_PUSH:
            begin
                top_next = val_reg;
                sp_next  = sp_reg + DEPTH_W'(1);
            end
            ACT_POP:
            begin
                top_next = res_reg;
                sp_next  = sp_minus1;
            end
            default:
            begin
                top_next = top_reg;
                sp_next  = sp_reg;
            end
        endcase
    end

    // lhs is the entry read from memory, rhs the register-held top
    logic [FUNC_W-1:0] func_reg;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] diff;
    logic [DATA_W-1:0] prod;

    assign sum  = rd_data_reg + top_reg;
    assign diff = rd_data_reg - top_reg;
    assign prod = rd_data_reg * top_reg;

    assign rem_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsor_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            val_reg <= operand_value;
        if (cmd.alu_load)
        begin
            unique case (func_reg)
                FN_ADD:  res_reg <= sum;
                FN_SUB:  res_reg <= diff;
                default: res_reg <= prod;
            endcase
        end
        else if (cmd.div_fix)
            res_reg <= neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;
        if (cmd.div_start)
        begin
            rem_reg  <= '0;
            quo_reg  <= rd_data_reg[DATA_W-1] ? (DATA_W'(0) - rd_data_reg) : rd_data_reg;
            dsor_reg <= top_reg[DATA_W-1] ? (DATA_W'(0) - top_reg) : top_reg;
            neg_reg  <= rd_data_reg[DATA_W-1] ^ top_reg[DATA_W-1];
        end
        else if (cmd.div_step)
        begin
            if (!rem_diff[DATA_W])
            begin
                rem_reg <= rem_diff[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
        if (cmd.commit)
        begin
            top_reg        <= top_next;
            out_top_reg    <= (sp_next == '0) ? '0 : top_next;
            out_depth_reg  <= sp_next;
            out_status_reg <= cmd.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            func_reg      <= FN_PUSH;
        end
        else
        begin
            if (cmd.accept)
                func_reg <= func;
            if (cmd.commit)
            begin
                sp_reg        <= sp_next;
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
                out_valid_reg <= 1'b0;
            if (cmd.div_start)
                cnt_reg <= '0;
            else if (cmd.div_step)
                cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign stat.full        = (sp_reg == DEPTH_W'(STACK_DEPTH));
    assign stat.few_entries = (sp_reg < DEPTH_W'(2));
    assign stat.rhs_zero    = (top_reg == '0);
    assign stat.div_last    = (cnt_reg == CNT_LAST);
    assign stat.out_free    = !out_valid_reg || res.ready;

    assign res.valid       = out_valid_reg;
    assign res.top_value   = $signed(out_top_reg);
    assign res.stack_depth = out_depth_reg;
    assign res.status      = out_status_reg;

endmodule

@@ design/postfix_stack_evaluator.sv @@
// Postfix evaluation stack, one token per item and one result item per token.
// A push, an ignored code or a rejected token (overflow, underflow, divide by
// zero) goes from acceptance straight to the finish state; add, subtract and
// multiply first pass an execute state that registers the ALU result (the
// second entry is read from the stack memory at acceptance); divide passes
// execute, the 32-step radix-2 divider and a sign fix-up state. Tokens
// are taken one at a time: a new token is accepted as soon as the previous
// one has been written to the output register, even while that result still
// waits. The stack memory is not cleared at reset; only live entries are used.
`include "postfix_stack_evaluator_assert.svh"

module postfix_stack_evaluator (
    input  logic      clk,
    input  logic      rst_n,
    pse_tok_if.sink   tok,
    pse_res_if.source res
);
    import pse_pkg::*;

    ctrl_t cmd;
    stat_t stat;

    pse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok.valid),
        .tok_func  (tok.func),
        .tok_ready (tok.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pse_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_value ($unsigned(tok.operand_value)),
        .func          (tok.func),
        .cmd           (cmd),
        .stat          (stat),
        .res           (res)
    );

    `PSE_ASSERT_NOW(a_depth_bound, res.valid, res.stack_depth <= DEPTH_W'(STACK_DEPTH), "stack depth beyond capacity")
    `PSE_ASSERT_NOW(a_overflow_full, res.valid && res.status == ST_OVERFLOW, res.stack_depth == DEPTH_W'(STACK_DEPTH), "overflow reported on a stack that is not full")
    `PSE_ASSERT_NOW(a_underflow_short, res.valid && res.status == ST_UNDERFLOW, res.stack_depth < DEPTH_W'(2), "underflow reported with two or more entries")
    `PSE_ASSERT_NEXT(a_commit_lands, cmd.commit, res.valid, "committed result did not reach the output")

endmodule
